// ===== sv/bbn_pkg.sv =====
// Shared types and constants for the binned box NMS block.
package bbn_pkg;

	localparam int unsigned CoordW   = 12;
	localparam int unsigned ScoreW   = 32;
	localparam int unsigned BinW     = 6;
	localparam int unsigned NumBins  = 60;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned KeptW    = 13;
	localparam logic [15:0] OffLimit = 16'd64880;

	localparam logic [CfgIdxW-1:0] RegIouThr  = 2'd0;
	localparam logic [CfgIdxW-1:0] RegBinScl  = 2'd1;
	localparam logic [CfgIdxW-1:0] RegMaxKept = 2'd2;

	typedef struct packed {
		logic [CoordW-1:0] left;
		logic [CoordW-1:0] top;
		logic [CoordW-1:0] right;
		logic [CoordW-1:0] bottom;
		logic [ScoreW-1:0] score_bits;
		logic              set_last;
	} box_t;

	typedef struct packed {
		logic              kept;
		logic [CoordW-1:0] out_left;
		logic [CoordW-1:0] out_top;
		logic [CoordW-1:0] out_right;
		logic [CoordW-1:0] out_bottom;
		logic [ScoreW-1:0] out_score;
		logic              out_last;
	} res_t;

	// Front-end classification handed to the back end through the queue.
	typedef struct packed {
		box_t              box;
		logic [BinW-1:0]   bin;
		logic [24:0]       area;
		logic              bypass;
	} job_t;

	typedef enum logic [1:0] {
		FE_IDLE, FE_LOG, FE_MUL, FE_DONE
	} fe_state_t;

	typedef enum logic [2:0] {
		BE_IDLE, BE_RD, BE_CHK, BE_MUL, BE_CMP, BE_DONE
	} be_state_t;

endpackage

// ===== sv/bbn_if.sv =====
// Valid/ready channel interface carrying one item.
interface bbn_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/bbn_front.sv =====
// Front end: accepts boxes, computes area and area bin.
module bbn_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [15:0]            iou_thr,
	input  logic [15:0]            bin_scale,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  bbn_pkg::box_t          in_data,
	output logic                   job_valid,
	input  logic                   job_ready,
	output bbn_pkg::job_t          job_data
);
	import bbn_pkg::*;

	fe_state_t         st_q, st_nx;
	box_t              box_q;
	logic [24:0]       area_q;
	logic [31:0]       x_q;
	logic [20:0]       log_q;
	logic [3:0]        step_q;
	logic [36:0]       prod_q;
	logic              byp_q;
	logic [12:0]       wx, hx;
	logic [63:0]       sq;
	logic [31:0]       sq_n;
	logic [4:0]        msb;
	logic [12:0]       pre_bin;

	always_comb begin
		wx = (in_data.right >= in_data.left) ?
			13'(in_data.right - in_data.left) + 13'd1 : 13'd0;
		hx = (in_data.bottom >= in_data.top) ?
			13'(in_data.bottom - in_data.top) + 13'd1 : 13'd0;
	end

	// leading one of the area, at most 25 bits
	always_comb begin
		msb = '0;
		for (int i = 1; i < 25; i++)
			if (area_q[i]) msb = 5'(i);
	end

	always_comb begin
		sq   = 64'(x_q) * 64'(x_q);
		sq_n = sq[62:31];
	end

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			FE_IDLE: if (in_valid) st_nx = FE_LOG;
			FE_LOG:  if (step_q == 4'd15) st_nx = FE_MUL;
			FE_MUL:  st_nx = FE_DONE;
			FE_DONE: if (job_ready) st_nx = FE_IDLE;
			default: st_nx = FE_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (st_q == FE_IDLE);
		job_valid = (st_q == FE_DONE);
	end

	always_comb begin
		logic [12:0] up;
		up = 13'(prod_q[36:24]) + ((prod_q[23:0] != '0) ? 13'd1 : 13'd0);
		pre_bin = up;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= FE_IDLE;
		else st_q <= st_nx;
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			FE_IDLE: if (in_valid) begin
				box_q  <= in_data;
				area_q <= 25'(26'(wx) * 26'(hx));
				byp_q  <= (iou_thr > OffLimit);
				step_q <= 4'd0;
				log_q  <= '0;
				x_q    <= '0;
			end
			FE_LOG: begin
				if (step_q == 4'd0 && x_q == '0 && log_q == '0) begin
					// normalize mantissa to Q1.31, integer part of log2
					x_q   <= 32'((57'(area_q) << 31) >> msb);
					log_q <= 21'(msb) << 16;
				end else begin
					// square reached [2,4): fraction bit set, halve back
					if (sq[63]) begin
						log_q <= log_q | (21'd1 << (4'd15 - step_q));
						x_q <= sq[63:32];
					end else begin
						x_q <= sq_n;
					end
					step_q <= step_q + 4'd1;
				end
				if (area_q <= 25'd1) step_q <= 4'd15;
			end
			FE_MUL: prod_q <= 37'(log_q) * 37'(bin_scale);
			FE_DONE: begin end
			default: begin end
		endcase
	end

	always_comb begin
		job_data.box    = box_q;
		job_data.area   = area_q;
		job_data.bypass = byp_q;
		if (pre_bin < 13'd1) job_data.bin = BinW'(1);
		else if (pre_bin > 13'(NumBins)) job_data.bin = BinW'(NumBins);
		else job_data.bin = BinW'(pre_bin);
	end
endmodule

// ===== sv/bbn_queue.sv =====
// Two-entry queue between front and back ends.
module bbn_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  bbn_pkg::job_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output bbn_pkg::job_t rd_data
);
	import bbn_pkg::*;
	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
		end
	end

	always_ff @(posedge clk)
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_data;
endmodule

// ===== sv/bbn_back.sv =====
// Back end: scans kept store, decides, stores survivors, emits result.
module bbn_back #(
	parameter int MAX_KEPT = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [15:0]      iou_thr,
	input  logic [12:0]      max_kept,
	input  logic             job_valid,
	output logic             job_ready,
	input  bbn_pkg::job_t    job_data,
	output logic             res_valid,
	input  logic             res_ready,
	output bbn_pkg::res_t    res_data
);
	import bbn_pkg::*;
	localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CW = AW + 1;

	logic [4*CoordW+BinW-1:0] store [MAX_KEPT];
	be_state_t      st_q, st_nx;
	job_t           job_q;
	logic [CW-1:0]  cnt_q, k_q, limit;
	logic [4*CoordW+BinW-1:0] ent_q;
	logic           keep_q, hit;
	logic [24:0]    inter_q, oarea_q;
	logic [41:0]    lhs_q, rhs_q;
	logic [12:0]    ow, oh, ew, eh;
	logic [CoordW-1:0] el, et, er, eb;
	logic [CoordW-1:0] ox1, ox2, oy1, oy2;
	logic [BinW-1:0]   eb_bin;
	logic           near, ovl;
	logic [25:0]    uni;

	always_comb begin
		if (32'(max_kept) < 32'(MAX_KEPT)) limit = CW'(max_kept);
		else limit = CW'(MAX_KEPT);
	end

	always_comb begin
		{el, et, er, eb, eb_bin} = ent_q;
		near = ({1'b0, eb_bin} + 7'd1 >= {1'b0, job_q.bin}) &&
			({1'b0, eb_bin} <= {1'b0, job_q.bin} + 7'd1);
		ox1 = (job_q.box.left > el) ? job_q.box.left : el;
		ox2 = (job_q.box.right < er) ? job_q.box.right : er;
		oy1 = (job_q.box.top > et) ? job_q.box.top : et;
		oy2 = (job_q.box.bottom < eb) ? job_q.box.bottom : eb;
		ovl = (ox2 >= ox1) && (oy2 >= oy1);
		ow = 13'(ox2 - ox1) + 13'd1;
		oh = 13'(oy2 - oy1) + 13'd1;
		ew = (er >= el) ? 13'(er - el) + 13'd1 : 13'd0;
		eh = (eb >= et) ? 13'(eb - et) + 13'd1 : 13'd0;
		uni = 26'(job_q.area) + 26'(oarea_q) - 26'(inter_q);
		hit = lhs_q > rhs_q;
	end

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			BE_IDLE: if (job_valid) st_nx = BE_RD;
			BE_RD: begin
				if (job_q.bypass || cnt_q >= limit || k_q >= cnt_q) st_nx = BE_DONE;
				else st_nx = BE_CHK;
			end
			BE_CHK: st_nx = (near && ovl) ? BE_MUL : BE_RD;
			BE_MUL: st_nx = BE_CMP;
			BE_CMP: st_nx = hit ? BE_DONE : BE_RD;
			BE_DONE: if (res_ready) st_nx = BE_IDLE;
			default: st_nx = BE_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (st_q == BE_IDLE);
		res_valid = (st_q == BE_DONE);
		res_data.kept       = keep_q;
		res_data.out_left   = job_q.box.left;
		res_data.out_top    = job_q.box.top;
		res_data.out_right  = job_q.box.right;
		res_data.out_bottom = job_q.box.bottom;
		res_data.out_score  = job_q.box.score_bits;
		res_data.out_last   = job_q.box.set_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BE_IDLE; cnt_q <= '0; keep_q <= 1'b0; k_q <= '0;
		end else begin
			st_q <= st_nx;
			unique case (st_q)
				BE_IDLE: if (job_valid) begin
					k_q <= '0; keep_q <= 1'b1;
				end
				BE_RD: begin
					if (!job_q.bypass && cnt_q >= limit) keep_q <= 1'b0;
					else if (!job_q.bypass && k_q >= cnt_q) cnt_q <= cnt_q + 1'b1;
				end
				BE_CHK: k_q <= k_q + 1'b1;
				BE_MUL: begin end
				BE_CMP: if (hit) keep_q <= 1'b0;
				BE_DONE: if (res_ready && job_q.box.set_last) cnt_q <= '0;
				default: begin end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == BE_IDLE && job_valid) job_q <= job_data;
		if (st_q == BE_RD) begin
			ent_q <= store[k_q[AW-1:0]];
			if (!job_q.bypass && cnt_q < limit && k_q >= cnt_q)
				store[cnt_q[AW-1:0]] <= {job_q.box.left, job_q.box.top,
					job_q.box.right, job_q.box.bottom, job_q.bin};
		end
		if (st_q == BE_CHK) begin
			inter_q <= 25'(26'(ow) * 26'(oh));
			oarea_q <= 25'(26'(ew) * 26'(eh));
		end
		if (st_q == BE_MUL) begin
			lhs_q <= {1'b0, inter_q, 16'd0};
			rhs_q <= 42'(uni) * 42'(iou_thr);
		end
	end
endmodule

// ===== sv/binned_box_nms_core.sv =====
// Top level of the binned box NMS block.
// The back end scans the stored boxes, adding a multiply and compare for each
//   overlapping box in a neighbor bin; an empty store, suppression off or the kept
//   limit reached skip the scan. A box of area 0 or 1 skips the log2 squaring.
// The front end takes a new box only after its job has gone to the queue, and the
//   back end only after its result is taken; a two-entry queue lets them overlap.
// Reset clears control, counters and config registers to defaults; datapath registers
//   and store are left undefined since only entries below the kept count are used.
module binned_box_nms_core #(
	parameter int MAX_KEPT = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bbn_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [bbn_pkg::CfgDataW-1:0] cfg_wdata,
	bbn_if.sink                         boxes,
	bbn_if.source                       results
);
	import bbn_pkg::*;

	logic [15:0] iou_thr_q, bin_scale_q;
	logic [12:0] max_kept_q;
	logic        jv_f, jr_f, jv_b, jr_b;
	job_t        jd_f, jd_b;

	// Configuration registers; unknown index ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iou_thr_q   <= 16'd45875;
			bin_scale_q <= 16'd497;
			max_kept_q  <= 13'd4096;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegIouThr:  iou_thr_q   <= cfg_wdata;
				RegBinScl:  bin_scale_q <= cfg_wdata;
				RegMaxKept: max_kept_q  <= cfg_wdata[12:0];
				default: begin end
			endcase
		end
	end

	bbn_front u_front (
		.clk, .arst_n, .iou_thr(iou_thr_q), .bin_scale(bin_scale_q),
		.in_valid(boxes.valid), .in_ready(boxes.ready), .in_data(boxes.data),
		.job_valid(jv_f), .job_ready(jr_f), .job_data(jd_f));

	bbn_queue u_queue (
		.clk, .arst_n, .wr_valid(jv_f), .wr_ready(jr_f), .wr_data(jd_f),
		.rd_valid(jv_b), .rd_ready(jr_b), .rd_data(jd_b));

	bbn_back #(.MAX_KEPT(MAX_KEPT)) u_back (
		.clk, .arst_n, .iou_thr(iou_thr_q), .max_kept(max_kept_q),
		.job_valid(jv_b), .job_ready(jr_b), .job_data(jd_b),
		.res_valid(results.valid), .res_ready(results.ready),
		.res_data(results.data));
endmodule

// ===== sv/bbn_checker.sv =====
// Port-level checker for the binned box NMS top level.
module bbn_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_rst_out: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result after reset");
	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("front took two items");
endmodule

bind binned_box_nms_core bbn_checker u_chk (
	.clk, .arst_n, .in_valid(boxes.valid), .in_ready(boxes.ready),
	.out_valid(results.valid), .out_ready(results.ready));

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for binned_box_nms_core: random and directed box sets.
module tb_top;
	import bbn_pkg::*;

	localparam int StoreDepth = 4096;
	localparam int NumBins    = 60;
	localparam int IdleLimit  = 40000;
	localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_wdata = '0;

	bbn_if #(.T(box_t)) box_ch ();
	bbn_if #(.T(res_t)) res_ch ();

	binned_box_nms_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.boxes    (box_ch),
		.results  (res_ch)
	);

	always #5 clk = ~clk;

	// Shadow of the block's registers and kept-box store.
	logic [15:0] thr_q16 = 16'd45875;
	logic [15:0] scale_q8 = 16'd497;
	logic [12:0] kept_max = 13'd4096;
	logic [CoordW-1:0] kl [StoreDepth];
	logic [CoordW-1:0] kt [StoreDepth];
	logic [CoordW-1:0] kr [StoreDepth];
	logic [CoordW-1:0] kb [StoreDepth];
	int unsigned       kbin [StoreDepth];
	int unsigned       n_kept = 0;

	box_t pending_boxes [$];
	res_t expected_results [$];
	int   errors = 0;
	bit   steady = 1'b0;  // no idling on either side while set

	task automatic add_box(box_t bx);
		pending_boxes = {pending_boxes, bx};
	endtask

	// Q.16 log2 of the area: integer part from the top bit, fraction by squaring.
	function automatic longint unsigned log2_fix(longint unsigned a);
		longint unsigned x, r;
		int n;
		if (a <= 1) return 0;
		n = 0;
		while (n < 62 && (a >> (n + 1)) != 0) n++;
		x = (a << 31) >> n;
		r = longint'(n) << 16;
		for (int i = 15; i >= 0; i--) begin
			x = (x * x) >> 31;
			if (x >= (64'd1 << 32)) begin
				r |= 64'd1 << i;
				x >>= 1;
			end
		end
		return r;
	endfunction

	function automatic longint unsigned span(int unsigned lo, int unsigned hi);
		return hi >= lo ? longint'(hi - lo) + 1 : 0;
	endfunction

	// Greedy suppression of one box against kept boxes in neighbor bins.
	function automatic res_t suppress_box(box_t bx);
		res_t o;
		longint unsigned area, p, bn, inter, other, uni;
		int unsigned lim, x1, x2, y1, y2;
		bit keep;
		keep = 1'b1;
		if (thr_q16 <= OffLimit) begin
			lim = kept_max < StoreDepth ? kept_max : StoreDepth;
			if (n_kept >= lim) begin
				keep = 1'b0;
			end else begin
				area = span(bx.left, bx.right) * span(bx.top, bx.bottom);
				p = log2_fix(area) * scale_q8;
				bn = (p + 64'hFFFFFF) >> 24;
				if (bn < 1) bn = 1;
				if (bn > NumBins) bn = NumBins;
				for (int k = 0; k < n_kept && keep; k++) begin
					if (kbin[k] + 1 >= bn && kbin[k] <= bn + 1) begin
						x1 = bx.left > kl[k] ? bx.left : kl[k];
						x2 = bx.right < kr[k] ? bx.right : kr[k];
						y1 = bx.top > kt[k] ? bx.top : kt[k];
						y2 = bx.bottom < kb[k] ? bx.bottom : kb[k];
						if (x1 <= x2 && y1 <= y2) begin
							inter = (longint'(x2 - x1) + 1) * (longint'(y2 - y1) + 1);
							other = span(kl[k], kr[k]) * span(kt[k], kb[k]);
							uni = area + other - inter;
							if (inter * 65536 > longint'(thr_q16) * uni) keep = 1'b0;
						end
					end
				end
				if (keep) begin
					kl[n_kept] = bx.left;
					kt[n_kept] = bx.top;
					kr[n_kept] = bx.right;
					kb[n_kept] = bx.bottom;
					kbin[n_kept] = int'(bn);
					n_kept++;
				end
			end
		end
		if (bx.set_last) n_kept = 0;
		o.kept = keep;
		o.out_left = bx.left;
		o.out_top = bx.top;
		o.out_right = bx.right;
		o.out_bottom = bx.bottom;
		o.out_score = bx.score_bits;
		o.out_last = bx.set_last;
		return o;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Acceptance flags, sampled at the rising edge, used by the drivers.
	bit box_took = 1'b0;
	bit res_took = 1'b0;
	int idle_cycles = 0;

	always @(posedge clk) begin
		res_t got, want, pred;
		box_took <= box_ch.valid && box_ch.ready;
		res_took <= res_ch.valid && res_ch.ready;
		if (res_ch.valid && res_ch.ready) begin
			got = res_ch.data;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected item", got.out_score, 0);
			end else begin
				want = expected_results.pop_front();
				if (got.kept !== want.kept) report_mismatch("kept", got.kept, want.kept);
				if (got.out_left !== want.out_left)
					report_mismatch("out_left", got.out_left, want.out_left);
				if (got.out_top !== want.out_top)
					report_mismatch("out_top", got.out_top, want.out_top);
				if (got.out_right !== want.out_right)
					report_mismatch("out_right", got.out_right, want.out_right);
				if (got.out_bottom !== want.out_bottom)
					report_mismatch("out_bottom", got.out_bottom, want.out_bottom);
				if (got.out_score !== want.out_score)
					report_mismatch("out_score", got.out_score, want.out_score);
				if (got.out_last !== want.out_last)
					report_mismatch("out_last", got.out_last, want.out_last);
			end
		end
		// Predict at acceptance; config only changes while the block is idle.
		if (box_ch.valid && box_ch.ready) begin
			pred = suppress_box(box_ch.data);
			expected_results = {expected_results, pred};
		end
	end

	// Box driver: changes at the falling edge, one draw of idle cycles per item.
	int box_gap = 0;
	always @(negedge clk) begin
		bit v;
		v = box_ch.valid;
		if (!arst_n) v = 1'b0;
		if (v && box_took) v = 1'b0;
		if (!v && arst_n) begin
			if (box_gap > 0) begin
				box_gap--;
			end else if (pending_boxes.size() > 0) begin
				box_ch.data <= pending_boxes.pop_front();
				v = 1'b1;
				box_gap = steady ? 0 : $urandom_range(0, 7);
			end
		end
		box_ch.valid <= v;
	end

	// Result sink: stalls a drawn number of cycles before each item.
	int res_stall = 0;
	always @(negedge clk) begin
		if (res_took) res_stall = steady ? 0 : $urandom_range(0, 7);
		else if (res_stall > 0) res_stall--;
		res_ch.ready <= arst_n && res_stall == 0;
	end

	// Watchdog on cycles with no item moving on either channel.
	always @(posedge clk) begin
		if ((box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [CoordW-1:0] clamp_coord(int v);
		if (v < 0) return '0;
		if (v > 4095) return 12'hFFF;
		return v[CoordW-1:0];
	endfunction

	function automatic box_t mk_box(int l, int t, int r, int b, logic [31:0] s, bit last);
		box_t bx;
		bx.left = clamp_coord(l);
		bx.top = clamp_coord(t);
		bx.right = clamp_coord(r);
		bx.bottom = clamp_coord(b);
		bx.score_bits = s;
		bx.set_last = last;
		return bx;
	endfunction

	// Random sets: mostly jittered copies of a seed box so that overlaps
	// actually suppress, plus some fully random and inverted boxes.
	task automatic queue_sets(int count);
		int sz, l, t, w, h, pick, dj;
		logic [95:0] rnd;
		box_t bx;
		while (count > 0) begin
			sz = $urandom_range(1, 12);
			l = $urandom_range(0, 4095);
			t = $urandom_range(0, 4095);
			case ($urandom_range(0, 2))
				0: begin w = $urandom_range(0, 15); h = $urandom_range(0, 15); end
				1: begin w = $urandom_range(0, 400); h = $urandom_range(0, 400); end
				default: begin w = $urandom_range(0, 4095); h = $urandom_range(0, 4095); end
			endcase
			for (int i = 0; i < sz; i++) begin
				pick = $urandom_range(0, 9);
				dj = (w + h) / 8 + 1;
				if (pick == 0) begin
					rnd = {$urandom(), $urandom(), $urandom()};
					bx = rnd[$bits(box_t)-1:0];
				end else if (pick == 1) begin
					bx = mk_box(l + w, t, l, t + h, $urandom(), 1'b0);
				end else begin
					bx = mk_box(l + $urandom_range(0, dj) - dj / 2,
						t + $urandom_range(0, dj) - dj / 2,
						l + w + $urandom_range(0, dj) - dj / 2,
						t + h + $urandom_range(0, dj) - dj / 2, $urandom(), 1'b0);
				end
				if (pick != 0) bx.set_last = (i == sz - 1);
				add_box(bx);
			end
			count -= sz;
		end
	endtask

	// Wait until every queued item went in and every result came back.
	task automatic drain;
		wait (pending_boxes.size() == 0 && !box_ch.valid && expected_results.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			RegIouThr:  thr_q16 = val;
			RegBinScl:  scale_q8 = val;
			RegMaxKept: kept_max = val[12:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(logic [15:0] thr, logic [15:0] scl, logic [15:0] mk, int n,
			bit quiet);
		write_reg(RegIouThr, thr);
		write_reg(RegBinScl, scl);
		write_reg(RegMaxKept, mk);
		steady = quiet;
		queue_sets(n);
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed set with reset defaults: extremes, duplicates, inverted box.
		add_box(mk_box(0, 0, 0, 0, 32'h0, 1'b0));
		add_box(mk_box(0, 0, 0, 0, 32'hFFFFFFFF, 1'b0));
		add_box(mk_box(0, 0, 4095, 4095, 32'h12345678, 1'b0));
		add_box(mk_box(0, 0, 4095, 4094, 32'h9ABCDEF0, 1'b0));
		add_box(mk_box(4095, 4095, 0, 0, 32'h55555555, 1'b0));
		add_box(mk_box(4095, 4095, 4095, 4095, 32'hAAAAAAAA, 1'b0));
		add_box(mk_box(100, 100, 199, 199, 32'h1, 1'b0));
		add_box(mk_box(110, 110, 209, 209, 32'h2, 1'b0));
		add_box(mk_box(150, 150, 249, 249, 32'h3, 1'b0));
		add_box(mk_box(100, 100, 199, 199, 32'h4, 1'b1));
		// Same box again in a fresh set must survive: store was emptied.
		add_box(mk_box(100, 100, 199, 199, 32'h5, 1'b1));
		drain();
		queue_sets(120);
		drain();

		// Any overlap suppresses; unit scale.
		run_phase(16'd0, 16'd256, 16'd4096, 80, 1'b0);
		// Threshold at the edge of still active; widest scale clamps bins high.
		run_phase(16'd64880, 16'd65535, 16'd3, 80, 1'b1);
		// Suppression off: every box kept, limit ignored.
		run_phase(16'd64881, 16'd0, 16'd0, 60, 1'b0);
		run_phase(16'd65535, 16'd497, 16'd4096, 40, 1'b0);
		// Out-of-range register index must change nothing.
		write_reg(RegSpare, 16'hFFFF);
		queue_sets(30);
		drain();
		// Zero kept limit drops every box.
		run_phase(16'd32768, 16'd497, 16'd0, 40, 1'b0);
		// Single bin for all, one kept box per set.
		run_phase(16'd45875, 16'd0, 16'd1, 60, 1'b0);
		// Limit register above the store size, masked and capped.
		run_phase(16'd32768, 16'd1, 16'hFFFF, 80, 1'b0);
		run_phase(16'd45875, 16'd497, 16'd4096, 120, 1'b0);

		if (errors == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
